[rtl/rpd_pkg.sv]
`default_nettype none

package rpd_pkg;

  // Widths fixed by the result and configuration fields.
  localparam int OUT_BITS = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CHAR_BITS = 8;

  // Default sizes of the position and count registers.
  localparam int COORD_BITS_DEFAULT = 16;
  localparam int COUNT_BITS_DEFAULT = 16;

  // Decimal base used when a digit extends the repeat count.
  localparam int DECIMAL_BASE = 10;

  // Pattern alphabet.
  localparam logic [CHAR_BITS-1:0] CHAR_ZERO = 8'h30;  // '0'
  localparam logic [CHAR_BITS-1:0] CHAR_NINE = 8'h39;  // '9'
  localparam logic [CHAR_BITS-1:0] CHAR_DEAD = 8'h62;  // 'b'
  localparam logic [CHAR_BITS-1:0] CHAR_LIVE = 8'h6f;  // 'o'
  localparam logic [CHAR_BITS-1:0] CHAR_EOL  = 8'h24;  // '$'
  localparam logic [CHAR_BITS-1:0] CHAR_END  = 8'h21;  // '!'

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ORIGIN_X = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ORIGIN_Y = 2'd1;

  // One input beat as held in the input register.
  typedef struct packed {
    logic [CHAR_BITS-1:0] pattern_char;
    logic                 first_char;
  } rpd_item_t;

  // One result beat, plus a flag saying whether the item produced one.
  typedef struct packed {
    logic                       emit;
    logic signed [OUT_BITS-1:0] cell_x;
    logic signed [OUT_BITS-1:0] cell_y;
    logic [OUT_BITS-1:0]        run_length;
    logic                       pattern_end;
  } rpd_result_t;

endpackage

`default_nettype wire

[rtl/rpd_in_reg.sv]
`default_nettype none

module rpd_in_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire rpd_pkg::rpd_item_t in_item,
  output logic                   in_stall,
  input  wire logic              advance,
  output logic                   stg_valid,
  output rpd_pkg::rpd_item_t     stg_item
);
  import rpd_pkg::*;

  logic accept;

  // The held beat leaves when the result side can take it.
  assign in_stall = stg_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else begin
      stg_valid <= accept || (stg_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_item <= in_item;
    end
  end

endmodule

`default_nettype wire

[rtl/rpd_step.sv]
`default_nettype none

module rpd_step #(
  parameter int COORD_BITS = rpd_pkg::COORD_BITS_DEFAULT,
  parameter int COUNT_BITS = rpd_pkg::COUNT_BITS_DEFAULT
) (
  input  wire rpd_pkg::rpd_item_t               item,
  input  wire logic [COORD_BITS-1:0]            column,
  input  wire logic [COORD_BITS-1:0]            row,
  input  wire logic [COUNT_BITS-1:0]            repeat_count,
  input  wire logic                             stopped,
  input  wire logic signed [rpd_pkg::OUT_BITS-1:0] origin_x,
  input  wire logic signed [rpd_pkg::OUT_BITS-1:0] origin_y,
  output logic [COORD_BITS-1:0]                 column_next,
  output logic [COORD_BITS-1:0]                 row_next,
  output logic [COUNT_BITS-1:0]                 repeat_count_next,
  output logic                                  stopped_next,
  output rpd_pkg::rpd_result_t                  result
);
  import rpd_pkg::*;

  localparam int SUM_BITS  = (COORD_BITS > COUNT_BITS) ? COORD_BITS : COUNT_BITS;
  localparam int POS_BITS  = (COORD_BITS > OUT_BITS) ? COORD_BITS : OUT_BITS;
  localparam int LEN_BITS  = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS + 1;
  localparam int PROD_BITS = COUNT_BITS + 4;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [COORD_BITS-1:0] col0;
  logic [COORD_BITS-1:0] row0;
  logic [COUNT_BITS-1:0] cnt0;
  logic                  stop0;
  logic [COUNT_BITS-1:0] n;
  logic [SUM_BITS-1:0]   col_sum;
  logic [SUM_BITS-1:0]   row_sum;
  logic [PROD_BITS-1:0]  prod;
  logic [POS_BITS-1:0]   col_w;
  logic [POS_BITS-1:0]   row_w;
  logic [LEN_BITS-1:0]   n_w;
  logic [OUT_BITS-1:0]   run_len;
  logic                  is_digit;

  // A first-flagged beat starts from a cleared position and count.
  assign col0  = item.first_char ? '0 : column;
  assign row0  = item.first_char ? '0 : row;
  assign cnt0  = item.first_char ? '0 : repeat_count;
  assign stop0 = item.first_char ? 1'b0 : stopped;

  // A missing or zero count means one.
  assign n = (cnt0 == '0) ? COUNT_BITS'(1) : cnt0;

  assign col_sum = SUM_BITS'(col0) + SUM_BITS'(n);
  assign row_sum = SUM_BITS'(row0) + SUM_BITS'(n);

  // Count times ten is count times eight plus count times two.
  assign prod = (PROD_BITS'(cnt0) << 3) + (PROD_BITS'(cnt0) << 1)
              + PROD_BITS'(item.pattern_char - CHAR_ZERO);

  assign col_w   = POS_BITS'(col0);
  assign row_w   = POS_BITS'(row0);
  assign n_w     = LEN_BITS'(n);
  assign run_len = (n_w[LEN_BITS-1:OUT_BITS] != '0) ? {OUT_BITS{1'b1}}
                                                    : n_w[OUT_BITS-1:0];

  assign is_digit = (item.pattern_char >= CHAR_ZERO) && (item.pattern_char <= CHAR_NINE);

  always_comb begin
    column_next       = col0;
    row_next          = row0;
    repeat_count_next = cnt0;
    stopped_next      = stop0;
    result            = '0;
    priority if (stop0) begin
      // Stopped: the beat is dropped.
    end else if (is_digit) begin
      repeat_count_next = (prod > PROD_BITS'(COUNT_MAX)) ? COUNT_MAX
                                                         : prod[COUNT_BITS-1:0];
    end else if (item.pattern_char == CHAR_DEAD) begin
      repeat_count_next = '0;
      column_next       = col_sum[COORD_BITS-1:0];
    end else if (item.pattern_char == CHAR_LIVE) begin
      repeat_count_next = '0;
      column_next       = col_sum[COORD_BITS-1:0];
      result.emit       = 1'b1;
      result.cell_x     = origin_x + signed'(col_w[OUT_BITS-1:0]);
      result.cell_y     = origin_y + signed'(row_w[OUT_BITS-1:0]);
      result.run_length = run_len;
    end else if (item.pattern_char == CHAR_EOL) begin
      repeat_count_next = '0;
      row_next          = row_sum[COORD_BITS-1:0];
      column_next       = '0;
    end else if (item.pattern_char == CHAR_END) begin
      stopped_next       = 1'b1;
      result.emit        = 1'b1;
      result.pattern_end = 1'b1;
    end else begin
      // Any other character leaves the state alone.
    end
  end

endmodule

`default_nettype wire

[rtl/rle_pattern_decoder_core.sv]
`default_nettype none

// Run-length pattern decoder. Each input beat carries one character of a
// Life-style run-length pattern. Digits build a repeat count, 'b' skips
// cells, 'o' produces one run beat (first cell position plus origin, and
// run length), '$' moves down rows and back to column zero, and '!'
// produces an end beat and makes the block drop characters until a beat
// flagged first_char arrives. A beat flagged first_char clears position,
// count and the stopped flag before its own character is decoded.
// The block takes one beat per cycle unless in_stall holds it back: a
// character waits in the input register, is decoded by combinational
// logic, and any result lands in the output register. While a result
// waits in the output register under out_stall the held character waits
// with it, so the input register and the output register together
// buffer up to two beats. The origin registers are written through the
// configuration port, which is always ready; they should be written only
// while no characters are in flight.
module rle_pattern_decoder_core #(
  parameter int COORD_BITS = rpd_pkg::COORD_BITS_DEFAULT,
  parameter int COUNT_BITS = rpd_pkg::COUNT_BITS_DEFAULT
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // Configuration port.
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [rpd_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  wire logic signed [rpd_pkg::OUT_BITS-1:0]   cfg_data,
  // Character input channel.
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [rpd_pkg::CHAR_BITS-1:0]         pattern_char,
  input  wire logic                                  first_char,
  // Result output channel.
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [rpd_pkg::OUT_BITS-1:0]        cell_x,
  output logic signed [rpd_pkg::OUT_BITS-1:0]        cell_y,
  output logic [rpd_pkg::OUT_BITS-1:0]               run_length,
  output logic                                       pattern_end
);
  import rpd_pkg::*;

  logic signed [OUT_BITS-1:0] origin_x;
  logic signed [OUT_BITS-1:0] origin_y;

  logic [COORD_BITS-1:0] column;
  logic [COORD_BITS-1:0] row;
  logic [COUNT_BITS-1:0] repeat_count;
  logic                  stopped;
  logic [COORD_BITS-1:0] column_next;
  logic [COORD_BITS-1:0] row_next;
  logic [COUNT_BITS-1:0] repeat_count_next;
  logic                  stopped_next;

  rpd_item_t   in_item;
  rpd_item_t   stg_item;
  logic        stg_valid;
  logic        advance;
  rpd_result_t result;

  // The configuration registers take a write in any cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ORIGIN_X: origin_x <= cfg_data;
        CFG_ORIGIN_Y: origin_y <= cfg_data;
        default: ;  // Unused indexes are ignored.
      endcase
    end
  end

  // The held character moves on whenever the output register is empty or
  // is being emptied in this cycle.
  assign advance = !out_valid || !out_stall;

  assign in_item.pattern_char = pattern_char;
  assign in_item.first_char   = first_char;

  rpd_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .in_stall  (in_stall),
    .advance   (advance),
    .stg_valid (stg_valid),
    .stg_item  (stg_item)
  );

  rpd_step #(
    .COORD_BITS (COORD_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .item              (stg_item),
    .column            (column),
    .row               (row),
    .repeat_count      (repeat_count),
    .stopped           (stopped),
    .origin_x          (origin_x),
    .origin_y          (origin_y),
    .column_next       (column_next),
    .row_next          (row_next),
    .repeat_count_next (repeat_count_next),
    .stopped_next      (stopped_next),
    .result            (result)
  );

  // Decoder state commits as the character leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      column       <= '0;
      row          <= '0;
      repeat_count <= '0;
      stopped      <= 1'b0;
    end else if (stg_valid && advance) begin
      column       <= column_next;
      row          <= row_next;
      repeat_count <= repeat_count_next;
      stopped      <= stopped_next;
    end
  end

  // Output register: filled by a character that produces a result, held
  // while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= stg_valid && result.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stg_valid && result.emit) begin
      cell_x      <= result.cell_x;
      cell_y      <= result.cell_y;
      run_length  <= result.run_length;
      pattern_end <= result.pattern_end;
    end
  end

  // An end beat carries no position and no length.
  a_end_beat_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && pattern_end |-> cell_x == '0 && cell_y == '0 && run_length == '0)
    else $error("end beat carries nonzero fields");

  // A run always covers at least one cell.
  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pattern_end |-> run_length != '0)
    else $error("run beat with zero length");

  // The input side only stalls while a character is held.
  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> stg_valid && out_valid)
    else $error("input stalled with nothing held");

  // Once stopped, only a first-flagged character can restart decoding.
  a_stay_stopped: assert property (@(posedge clk) disable iff (rst)
    stopped && !(stg_valid && advance && stg_item.first_char) |=> stopped)
    else $error("decoder left the stopped state without a first character");

  // Whenever a character is decoded while stopped and not first, no beat appears.
  a_stopped_silent: assert property (@(posedge clk) disable iff (rst)
    stopped && stg_valid && advance && !stg_item.first_char |=> !out_valid)
    else $error("result produced while stopped");

endmodule

`default_nettype wire
